### sv/line_sensor_pd_steering_top_defines.svh
// assertion macros shared by the line sensor steering block
`ifndef LINE_SENSOR_PD_STEERING_TOP_DEFINES_SVH
`define LINE_SENSOR_PD_STEERING_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LSPS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LSPS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/lsps_pkg.sv
// shared types, codes and functions of the line sensor steering block
package lsps_pkg;

    localparam int NUM_CH = 8;

    localparam logic [1:0] CMD_CAL    = 2'd0;
    localparam logic [1:0] CMD_FINISH = 2'd1;
    localparam logic [1:0] CMD_CTRL   = 2'd2;

    localparam logic [2:0] REG_GAIN_P      = 3'd0;
    localparam logic [2:0] REG_GAIN_D      = 3'd1;
    localparam logic [2:0] REG_DUTY_OFFSET = 3'd2;
    localparam logic [2:0] REG_LEFT_BIAS   = 3'd3;
    localparam logic [2:0] REG_DUTY_MAX    = 3'd4;

    localparam logic [4:0] GAIN_P_RST      = 5'd4;
    localparam logic [4:0] GAIN_D_RST      = 5'd10;
    localparam logic [5:0] DUTY_OFFSET_RST = 6'd1;
    localparam logic [5:0] LEFT_BIAS_RST   = 6'd20;
    localparam logic [7:0] DUTY_MAX_RST    = 8'd100;

    localparam logic [7:0] LOW_MARK_RST  = 8'd200;
    localparam logic [7:0] HIGH_MARK_RST = 8'd10;

    // front stage result handed to the pd datapath
    typedef struct packed {
        logic              ctl;
        logic [7:0]        pattern;
        logic signed [4:0] err;
        logic signed [5:0] diff;
    } lsps_front_t;

    typedef struct packed {
        logic              hit;
        logic signed [4:0] err;
    } lsps_lookup_t;

    // known line patterns and their position error
    function automatic lsps_lookup_t lookup_error(input logic [7:0] pat);
        lsps_lookup_t r;
        r.hit = 1'b1;
        case (pat)
            8'h01:   r.err = 5'sd15;
            8'h03:   r.err = 5'sd10;
            8'h02:   r.err = 5'sd5;
            8'h06:   r.err = 5'sd4;
            8'h04:   r.err = 5'sd3;
            8'h0C:   r.err = 5'sd2;
            8'h08:   r.err = 5'sd1;
            8'h10:   r.err = -5'sd1;
            8'h30:   r.err = -5'sd2;
            8'h20:   r.err = -5'sd3;
            8'h60:   r.err = -5'sd4;
            8'h40:   r.err = -5'sd5;
            8'hC0:   r.err = -5'sd10;
            8'h80:   r.err = -5'sd15;
            default:
            begin
                r.hit = 1'b0;
                r.err = 5'sd0;
            end
        endcase
        return r;
    endfunction

    // clamp to duty_max first, then to zero
    function automatic logic [7:0] clamp_duty(input logic signed [12:0] v,
                                              input logic [7:0] top);
        logic [7:0] r;
        if (v >= $signed({5'b0, top})) begin
            r = top;
        end else if (v <= 13'sd0) begin
            r = 8'd0;
        end else begin
            r = v[7:0];
        end
        return r;
    endfunction

endpackage

### sv/lsps_lane.sv
// one sensor channel: running min and max, threshold and compare
module lsps_lane (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [1:0] cmd,
    input  logic [7:0] sample,
    output logic       below
);
    import lsps_pkg::*;

    logic [7:0] low_mark_reg,  low_mark_next;
    logic [7:0] high_mark_reg, high_mark_next;
    logic [7:0] thr_reg,       thr_next;
    logic [8:0] mark_sum;

    assign below    = sample < thr_reg;
    assign mark_sum = {1'b0, low_mark_reg} + {1'b0, high_mark_reg};

    always_comb
    begin
        low_mark_next  = low_mark_reg;
        high_mark_next = high_mark_reg;
        thr_next       = thr_reg;
        if (accept) begin
            if (cmd == CMD_CAL) begin
                if (sample < low_mark_reg)  low_mark_next  = sample;
                if (sample > high_mark_reg) high_mark_next = sample;
            end else if (cmd == CMD_FINISH) begin
                thr_next = mark_sum[8:1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            low_mark_reg  <= LOW_MARK_RST;
            high_mark_reg <= HIGH_MARK_RST;
            thr_reg       <= 8'd0;
        end else begin
            low_mark_reg  <= low_mark_next;
            high_mark_reg <= high_mark_next;
            thr_reg       <= thr_next;
        end
    end

endmodule

### sv/lsps_merge.sv
// merges lane bits into the line pattern and tracks the line error
module lsps_merge (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic                 adv,
    input  logic [1:0]           cmd,
    input  logic [lsps_pkg::NUM_CH-1:0] below,
    output lsps_pkg::lsps_front_t front
);
    import lsps_pkg::*;

    logic signed [4:0] prev_error_reg, prev_error_next;
    logic [7:0]        pattern;
    lsps_lookup_t      hit_err;
    logic signed [4:0] err;
    lsps_front_t       front_reg, front_next;

    // channel 0 lands on the top bit, the others move down one
    assign pattern = {below[0], below[NUM_CH-1:1]};
    assign hit_err = lookup_error(pattern);
    assign err     = hit_err.hit ? hit_err.err : prev_error_reg;

    always_comb
    begin
        prev_error_next = prev_error_reg;
        front_next      = '0;
        if (cmd == CMD_CTRL) begin
            front_next.ctl     = 1'b1;
            front_next.pattern = pattern;
            front_next.err     = err;
            front_next.diff    = {err[4], err} - {prev_error_reg[4], prev_error_reg};
            if (accept) prev_error_next = err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            prev_error_reg <= 5'sd0;
        end else begin
            prev_error_reg <= prev_error_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) front_reg <= front_next;
    end

    assign front = front_reg;

endmodule

### sv/lsps_pd.sv
// pd term, duty offsets and clamps over two register stages
module lsps_pd (
    input  logic                  clk,
    input  logic                  adv,
    input  lsps_pkg::lsps_front_t front,
    input  logic [4:0]            gain_p,
    input  logic [4:0]            gain_d,
    input  logic [5:0]            duty_offset,
    input  logic [5:0]            left_bias,
    input  logic [7:0]            duty_max,
    output logic [7:0]            line_pattern,
    output logic signed [4:0]     line_error,
    output logic [7:0]            left_duty,
    output logic [7:0]            right_duty
);
    import lsps_pkg::*;

    logic signed [11:0] p_term, d_term, pv_next;
    logic               ctl_reg;
    logic [7:0]         pat_reg;
    logic signed [4:0]  err_reg;
    logic signed [11:0] pv_reg;
    logic signed [12:0] left_sum, right_sum;
    logic [7:0]         pat_out_reg, left_reg, right_reg;
    logic signed [4:0]  err_out_reg;

    assign p_term  = $signed({7'b0, gain_p}) * $signed({{7{front.err[4]}}, front.err});
    assign d_term  = $signed({7'b0, gain_d}) * $signed({{6{front.diff[5]}}, front.diff});
    assign pv_next = p_term + d_term;

    always_ff @(posedge clk)
    begin
        if (adv) begin
            ctl_reg <= front.ctl;
            pat_reg <= front.pattern;
            err_reg <= front.err;
            pv_reg  <= pv_next;
        end
    end

    assign left_sum  = {pv_reg[11], pv_reg} - $signed({7'b0, duty_offset})
                       + $signed({7'b0, left_bias});
    assign right_sum = {pv_reg[11], pv_reg} + $signed({7'b0, duty_offset});

    always_ff @(posedge clk)
    begin
        if (adv) begin
            pat_out_reg <= pat_reg;
            err_out_reg <= err_reg;
            left_reg    <= ctl_reg ? clamp_duty(left_sum, duty_max)  : 8'd0;
            right_reg   <= ctl_reg ? clamp_duty(right_sum, duty_max) : 8'd0;
        end
    end

    assign line_pattern = pat_out_reg;
    assign line_error   = err_out_reg;
    assign left_duty    = left_reg;
    assign right_duty   = right_reg;

endmodule

### sv/line_sensor_pd_steering_top.sv
// top level of the line sensor pd steering block
//
//   channel   handshake            payload
//   input     in_valid/in_ready    cmd, sample_0 .. sample_7
//   output    out_valid/out_ready  line_pattern, line_error, left_duty, right_duty
//   config    cfg_wr_en            cfg_index, cfg_wdata (no wait, no read-back)
//
// one transfer per cycle in both directions while out_ready keeps the pipe
// moving; results pass through the front, pd and clamp register stages
// the line error loop closes in the input cycle: the eight lanes compare in
// parallel and the merge stage updates the previous error in that same cycle
// reset restores calibration marks, thresholds, previous error, configuration registers and stage valid bits
// the whole pipe advances together; it holds only while a result waits for
// out_ready, and in_ready follows that same advance
module line_sensor_pd_steering_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        cmd,
    input  logic [7:0]        sample_0,
    input  logic [7:0]        sample_1,
    input  logic [7:0]        sample_2,
    input  logic [7:0]        sample_3,
    input  logic [7:0]        sample_4,
    input  logic [7:0]        sample_5,
    input  logic [7:0]        sample_6,
    input  logic [7:0]        sample_7,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        line_pattern,
    output logic signed [4:0] line_error,
    output logic [7:0]        left_duty,
    output logic [7:0]        right_duty,
    input  logic              cfg_wr_en,
    input  logic [2:0]        cfg_index,
    input  logic [7:0]        cfg_wdata
);
    import lsps_pkg::*;

`include "line_sensor_pd_steering_top_defines.svh"

    // configuration registers
    logic [4:0] gain_p_reg, gain_d_reg;
    logic [5:0] duty_offset_reg, left_bias_reg;
    logic [7:0] duty_max_reg;

    // pipeline control
    logic adv, accept;
    logic s1_valid_reg, s2_valid_reg, out_valid_reg;

    logic [7:0]        sample_arr [NUM_CH];
    logic [NUM_CH-1:0] below;
    lsps_front_t       front;

    assign sample_arr[0] = sample_0;
    assign sample_arr[1] = sample_1;
    assign sample_arr[2] = sample_2;
    assign sample_arr[3] = sample_3;
    assign sample_arr[4] = sample_4;
    assign sample_arr[5] = sample_5;
    assign sample_arr[6] = sample_6;
    assign sample_arr[7] = sample_7;

    // move whenever the output register is empty or being drained
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;
    assign accept   = in_valid && adv;

    // configuration writes, unknown indexes dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            gain_p_reg      <= GAIN_P_RST;
            gain_d_reg      <= GAIN_D_RST;
            duty_offset_reg <= DUTY_OFFSET_RST;
            left_bias_reg   <= LEFT_BIAS_RST;
            duty_max_reg    <= DUTY_MAX_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_GAIN_P:      gain_p_reg      <= cfg_wdata[4:0];
                REG_GAIN_D:      gain_d_reg      <= cfg_wdata[4:0];
                REG_DUTY_OFFSET: duty_offset_reg <= cfg_wdata[5:0];
                REG_LEFT_BIAS:   left_bias_reg   <= cfg_wdata[5:0];
                REG_DUTY_MAX:    duty_max_reg    <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // valid bits of the three stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    // one lane per sensor channel
    for (genvar k = 0; k < NUM_CH; k++) begin : g_lane
        lsps_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .accept (accept),
            .cmd    (cmd),
            .sample (sample_arr[k]),
            .below  (below[k])
        );
    end

    // pattern, lookup and previous error
    lsps_merge u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .adv    (adv),
        .cmd    (cmd),
        .below  (below),
        .front  (front)
    );

    // pd term and wheel duties
    lsps_pd u_pd (
        .clk          (clk),
        .adv          (adv),
        .front        (front),
        .gain_p       (gain_p_reg),
        .gain_d       (gain_d_reg),
        .duty_offset  (duty_offset_reg),
        .left_bias    (left_bias_reg),
        .duty_max     (duty_max_reg),
        .line_pattern (line_pattern),
        .line_error   (line_error),
        .left_duty    (left_duty),
        .right_duty   (right_duty)
    );

    // checks
    `LSPS_ASSERT_IMP(a_err_range, out_valid_reg, line_error != -5'sd16, "line error out of range")
    `LSPS_ASSERT_NXT(a_front_fill, accept, s1_valid_reg, "accepted transfer lost in front stage")
    `LSPS_ASSERT_NXT(a_out_fill, adv && s2_valid_reg, out_valid_reg, "result lost before output")

endmodule

### bench/line_sensor_pd_steering_top_tb.sv
// testbench for the line sensor pd steering block: directed and random items checked against a predictor
module line_sensor_pd_steering_top_tb;
    import lsps_pkg::*;

    // cmd value with no decode; the block must answer it with an all-zero result
    localparam logic [1:0] CMD_SPARE = 2'd3;

    // number of line patterns with a position error of their own
    localparam int NUM_KNOWN = 14;

    // cycles without any transfer before the run is declared hung
    localparam int QUIET_LIMIT = 1000;

    // pipe is three stages deep; a few spare cycles catch stray results
    localparam int TAIL_CYCLES = 8;

    // random part: phases of items, each under its own register setting
    localparam int NUM_PHASES = 11;
    localparam int PHASE_ITEMS = 150;

    typedef logic [NUM_CH-1:0][7:0] sample_set_t;

    // one expected steering result
    typedef struct packed {
        logic [7:0]        pattern;
        logic signed [4:0] err;
        logic [7:0]        left;
        logic [7:0]        right;
    } steer_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [1:0]        cmd = CMD_CAL;
    logic [7:0]        sample_0 = 8'd0;
    logic [7:0]        sample_1 = 8'd0;
    logic [7:0]        sample_2 = 8'd0;
    logic [7:0]        sample_3 = 8'd0;
    logic [7:0]        sample_4 = 8'd0;
    logic [7:0]        sample_5 = 8'd0;
    logic [7:0]        sample_6 = 8'd0;
    logic [7:0]        sample_7 = 8'd0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [7:0]        line_pattern;
    logic signed [4:0] line_error;
    logic [7:0]        left_duty;
    logic [7:0]        right_duty;
    logic              cfg_wr_en = 1'b0;
    logic [2:0]        cfg_index = REG_GAIN_P;
    logic [7:0]        cfg_wdata = 8'd0;

    // predictor copy of the registers
    logic [4:0] p_gain;
    logic [4:0] d_gain;
    logic [5:0] offset_reg;
    logic [5:0] bias_reg;
    logic [7:0] duty_top;

    // predictor copy of the calibration store and the error loop
    logic [7:0]        low_seen [NUM_CH];
    logic [7:0]        high_seen [NUM_CH];
    logic [7:0]        thr_level [NUM_CH];
    logic signed [4:0] last_err;

    steer_result_t pending_results[$];

    int fail_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int recv_stall_left = 0;
    int quiet_cycles = 0;

    line_sensor_pd_steering_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .sample_0     (sample_0),
        .sample_1     (sample_1),
        .sample_2     (sample_2),
        .sample_3     (sample_3),
        .sample_4     (sample_4),
        .sample_5     (sample_5),
        .sample_6     (sample_6),
        .sample_7     (sample_7),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .line_pattern (line_pattern),
        .line_error   (line_error),
        .left_duty    (left_duty),
        .right_duty   (right_duty),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // line patterns that map to a position error, right side first
    function automatic logic [7:0] known_pattern(input int idx);
        case (idx)
            0:       return 8'h01;
            1:       return 8'h03;
            2:       return 8'h02;
            3:       return 8'h06;
            4:       return 8'h04;
            5:       return 8'h0C;
            6:       return 8'h08;
            7:       return 8'h10;
            8:       return 8'h30;
            9:       return 8'h20;
            10:      return 8'h60;
            11:      return 8'h40;
            12:      return 8'hC0;
            default: return 8'h80;
        endcase
    endfunction

    function automatic logic signed [4:0] known_error(input int idx);
        case (idx)
            0:       return 5'sd15;
            1:       return 5'sd10;
            2:       return 5'sd5;
            3:       return 5'sd4;
            4:       return 5'sd3;
            5:       return 5'sd2;
            6:       return 5'sd1;
            7:       return -5'sd1;
            8:       return -5'sd2;
            9:       return -5'sd3;
            10:      return -5'sd4;
            11:      return -5'sd5;
            12:      return -5'sd10;
            default: return -5'sd15;
        endcase
    endfunction

    // channel 0 lands on the top bit, channel k on bit k-1
    function automatic int pattern_bit(input int chan);
        return (chan == 0) ? 7 : chan - 1;
    endfunction

    // upper limit is applied before the floor, so a zero limit forces zero
    function automatic logic [7:0] duty_limit(input int raw);
        int v;
        v = raw;
        if (v >= int'(duty_top))
            v = int'(duty_top);
        if (v <= 0)
            v = 0;
        return 8'(v);
    endfunction

    task automatic reset_predictor();
        p_gain = GAIN_P_RST;
        d_gain = GAIN_D_RST;
        offset_reg = DUTY_OFFSET_RST;
        bias_reg = LEFT_BIAS_RST;
        duty_top = DUTY_MAX_RST;
        for (int k = 0; k < NUM_CH; k++)
        begin
            low_seen[k] = LOW_MARK_RST;
            high_seen[k] = HIGH_MARK_RST;
            thr_level[k] = 8'd0;
        end
        last_err = 5'sd0;
    endtask

    // updates the model state for one accepted item and queues its result
    task automatic predict_steering(input logic [1:0] c, input sample_set_t s);
        steer_result_t r;
        logic [7:0] pat;
        logic signed [4:0] e;
        int pv;
        r = '0;
        case (c)
            CMD_CAL:
            begin
                for (int k = 0; k < NUM_CH; k++)
                begin
                    if (s[k] < low_seen[k])
                        low_seen[k] = s[k];
                    if (s[k] > high_seen[k])
                        high_seen[k] = s[k];
                end
            end
            CMD_FINISH:
            begin
                // marks stay as they are; only the thresholds move
                for (int k = 0; k < NUM_CH; k++)
                    thr_level[k] = 8'((9'(low_seen[k]) + 9'(high_seen[k])) >> 1);
            end
            CMD_CTRL:
            begin
                pat = 8'd0;
                for (int k = 0; k < NUM_CH; k++)
                    if (s[k] < thr_level[k])
                        pat[pattern_bit(k)] = 1'b1;
                // an unknown pattern holds the last error
                e = last_err;
                for (int i = 0; i < NUM_KNOWN; i++)
                    if (pat == known_pattern(i))
                        e = known_error(i);
                pv = int'(p_gain) * int'(e) + int'(d_gain) * (int'(e) - int'(last_err));
                last_err = e;
                r.pattern = pat;
                r.err = e;
                r.left = duty_limit(pv - int'(offset_reg) + int'(bias_reg));
                r.right = duty_limit(pv + int'(offset_reg));
            end
            default:
            begin
                // spare command: no state change, all-zero result
            end
        endcase
        pending_results.push_back(r);
    endtask

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // samples that produce the wanted pattern under the current thresholds;
    // a bit whose threshold is still zero cannot be set
    function automatic sample_set_t samples_for(input logic [7:0] pat);
        sample_set_t s;
        for (int k = 0; k < NUM_CH; k++)
        begin
            if (pat[pattern_bit(k)] && thr_level[k] != 8'd0)
                s[k] = 8'($urandom_range(int'(thr_level[k]) - 1, 0));
            else
                s[k] = 8'($urandom_range(255, int'(thr_level[k])));
        end
        return s;
    endfunction

    function automatic sample_set_t random_samples();
        sample_set_t s;
        for (int k = 0; k < NUM_CH; k++)
            s[k] = 8'($urandom);
        return s;
    endfunction

    function automatic sample_set_t flat_samples(input logic [7:0] v);
        sample_set_t s;
        for (int k = 0; k < NUM_CH; k++)
            s[k] = v;
        return s;
    endfunction

    // calibration readings scattered around a center, so the marks widen slowly
    function automatic sample_set_t cal_window(input int center);
        sample_set_t s;
        int v;
        for (int k = 0; k < NUM_CH; k++)
        begin
            v = center + int'($urandom_range(50, 0)) - 25;
            if (v < 0)
                v = 0;
            if (v > 255)
                v = 255;
            s[k] = 8'(v);
        end
        return s;
    endfunction

    // register value biased toward its two ends
    function automatic int pick_reg(input int top);
        case ($urandom_range(3, 0))
            0:       return 0;
            1:       return top;
            default: return int'($urandom_range(top, 0));
        endcase
    endfunction

    // one input transfer; the caller is always just past a rising edge
    task automatic send_item(input logic [1:0] c, input sample_set_t s);
        if (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(17, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        sample_0 <= s[0];
        sample_1 <= s[1];
        sample_2 <= s[2];
        sample_3 <= s[3];
        sample_4 <= s[4];
        sample_5 <= s[5];
        sample_6 <= s[6];
        sample_7 <= s[7];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_steering(c, s);
    endtask

    // stop sending and wait until every queued result has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // one register write; the caller lowers the enable after the last one
    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            REG_GAIN_P:      p_gain = val[4:0];
            REG_GAIN_D:      d_gain = val[4:0];
            REG_DUTY_OFFSET: offset_reg = val[5:0];
            REG_LEFT_BIAS:   bias_reg = val[5:0];
            REG_DUTY_MAX:    duty_top = val;
            default:
            begin
                // index past the register list is dropped
            end
        endcase
    endtask

    task automatic apply_config(input int gp, input int gd, input int off,
                                input int bias, input int top);
        wait_drained();
        write_reg(REG_GAIN_P, 8'(gp));
        write_reg(REG_GAIN_D, 8'(gd));
        write_reg(REG_DUTY_OFFSET, 8'(off));
        write_reg(REG_LEFT_BIAS, 8'(bias));
        write_reg(REG_DUTY_MAX, 8'(top));
        cfg_wr_en <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
        fail_count++;
    endtask

    // every result transfer is matched against the oldest expectation
    always @(posedge clk)
    begin : result_check
        steer_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with none pending, pattern", int'(line_pattern), 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (line_pattern !== want.pattern)
                    report_mismatch("line_pattern", int'(line_pattern), int'(want.pattern));
                if (line_error !== want.err)
                    report_mismatch("line_error", int'(line_error), int'(want.err));
                if (left_duty !== want.left)
                    report_mismatch("left_duty", int'(left_duty), int'(want.left));
                if (right_duty !== want.right)
                    report_mismatch("right_duty", int'(right_duty), int'(want.right));
            end
        end
    end

    // receiver: stalls come in bursts of random length
    always @(posedge clk)
    begin
        if (recv_stall_left == 0 && recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct)
            recv_stall_left = $urandom_range(17, 1);
        if (recv_stall_left > 0)
        begin
            out_ready <= 1'b0;
            recv_stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // hang detection: any transfer or register write restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // thresholds are still zero, so no sample can be below one; error holds at zero
    task automatic test_power_up();
        send_item(CMD_CTRL, flat_samples(8'd0));
        send_item(CMD_SPARE, flat_samples(8'hFF));
        wait_drained();
    endtask

    // finish on the reset marks gives threshold 105 on every channel
    task automatic test_finish_uncalibrated();
        send_item(CMD_FINISH, random_samples());
        send_item(CMD_CTRL, samples_for(8'h01));
        // every channel dark: all-ones pattern is not in the table
        send_item(CMD_CTRL, flat_samples(8'd0));
        wait_drained();
    endtask

    // writes past the register list must leave the reset values in place
    task automatic test_unused_registers();
        for (int k = 1; k <= 3; k++)
            write_reg(3'(REG_DUTY_MAX + k), 8'hFF);
        cfg_wr_en <= 1'b0;
        send_item(CMD_CTRL, samples_for(8'h80));
        wait_drained();
    endtask

    // two sweeps give each channel its own threshold, then finish
    task automatic test_calibration();
        sample_set_t s;
        for (int k = 0; k < NUM_CH; k++)
            s[k] = 8'(30 + 9 * k);
        send_item(CMD_CAL, s);
        for (int k = 0; k < NUM_CH; k++)
            s[k] = 8'(170 + 11 * k);
        send_item(CMD_CAL, s);
        send_item(CMD_FINISH, random_samples());
        send_item(CMD_CTRL, samples_for(8'h10));
        wait_drained();
    endtask

    // every table entry once, then an unknown pattern that must hold the error
    task automatic test_known_patterns();
        for (int i = 0; i < NUM_KNOWN; i++)
            send_item(CMD_CTRL, samples_for(known_pattern(i)));
        send_item(CMD_CTRL, samples_for(8'h81));
        send_item(CMD_SPARE, random_samples());
        wait_drained();
    endtask

    // bulk of the run: each phase gets its own registers and idling mix
    task automatic test_random_phases();
        int sel;
        int center;
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph == 0)
                apply_config(31, 31, 63, 63, 255);
            else if (ph == 1)
                apply_config(0, 0, 0, 0, 0);
            else if (ph == 2)
                apply_config(31, 31, 0, 63, 1);
            else
                apply_config(pick_reg(31), pick_reg(31), pick_reg(63), pick_reg(63),
                             pick_reg(255));

            // some phases run flat out; the last one always does
            if (ph == NUM_PHASES - 1 || ph % 4 == 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else
            begin
                send_idle_pct = $urandom_range(40, 5);
                recv_idle_pct = $urandom_range(40, 5);
            end

            // a fresh calibration sweep now and then
            if ($urandom_range(2, 0) == 0)
            begin
                center = $urandom_range(225, 30);
                repeat ($urandom_range(6, 1))
                    send_item(CMD_CAL, cal_window(center));
                send_item(CMD_FINISH, random_samples());
            end

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                sel = $urandom_range(99, 0);
                if (sel < 55)
                    send_item(CMD_CTRL, samples_for(known_pattern($urandom_range(13, 0))));
                else if (sel < 70)
                    send_item(CMD_CTRL, samples_for(8'($urandom)));
                else if (sel < 85)
                    send_item(CMD_CTRL, random_samples());
                else if (sel < 90)
                    send_item(CMD_SPARE, random_samples());
                else if (sel < 95)
                    send_item(CMD_CAL, cal_window($urandom_range(255, 0)));
                else
                    send_item(CMD_FINISH, random_samples());
            end
        end
        wait_drained();
    endtask

    // full-range calibration pins every threshold at 127, then steady steering
    task automatic test_full_scale();
        int sel;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_config(pick_reg(31), pick_reg(31), pick_reg(63), pick_reg(63), 255);
        send_item(CMD_CAL, flat_samples(8'd0));
        send_item(CMD_CAL, flat_samples(8'hFF));
        send_item(CMD_FINISH, flat_samples(8'hFF));
        send_item(CMD_CTRL, flat_samples(8'hFF));
        send_item(CMD_CTRL, flat_samples(8'd0));
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            sel = $urandom_range(9, 0);
            if (sel < 7)
                send_item(CMD_CTRL, samples_for(known_pattern($urandom_range(13, 0))));
            else
                send_item(CMD_CTRL, random_samples());
        end
        wait_drained();
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial
    begin
        reset_predictor();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_up();
        test_finish_uncalibrated();
        test_unused_registers();
        test_calibration();
        test_known_patterns();
        test_random_phases();
        test_full_scale();

        // nothing may trickle out once the queue is empty
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### line_sensor_pd_steering_top.f
+incdir+sv
sv/lsps_pkg.sv
sv/lsps_lane.sv
sv/lsps_merge.sv
sv/lsps_pd.sv
sv/line_sensor_pd_steering_top.sv
bench/line_sensor_pd_steering_top_tb.sv
